@@ sv/pfba_pkg.sv @@
package pfba_pkg;

  localparam int PAGE_W            = 15;
  localparam int WORD_BITS         = 32;
  localparam int BIT_SEL_W         = 5;
  localparam int WORD_IDX_W        = PAGE_W - BIT_SEL_W;
  localparam int CFG_W             = 11;
  localparam int BITMAP_WORDS_DEF  = 1024;
  localparam int ADDRESSABLE_WORDS = 1024;
  localparam logic [CFG_W-1:0]     WORDS_IN_USE_RST = 11'd1024;
  localparam logic [WORD_BITS-1:0] FULL_WORD        = 32'hffff_ffff;

  typedef enum logic [1:0] {
    CMD_MARK_USED = 2'd0,
    CMD_MARK_FREE = 2'd1,
    CMD_TEST      = 2'd2,
    CMD_FIND      = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [PAGE_W-1:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic              page_free;
    logic [PAGE_W-1:0] found_page;
    logic              out_of_memory;
  } out_item_t;

endpackage

@@ sv/page_frame_bitmap_allocator.sv @@
// Mark used, mark free and test go from transfer to result through a read of the
// bitmap word, a modify and write-back, and a move into the output register.
// Find reads one bitmap word per cycle through the single RAM read port and scans
// at most min(words_in_use, BITMAP_WORDS, 1024) words.
// One command is in flight at a time; the next is taken while a result waits.
// After reset a clearing pass writes zero to every word and no command is
// taken until it ends; words_in_use resets to 1024.
module page_frame_bitmap_allocator #(
  parameter int BITMAP_WORDS = pfba_pkg::BITMAP_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pfba_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pfba_pkg::out_item_t               out_data,
  input  logic                              cfg_wr_en,
  input  logic [pfba_pkg::CFG_W-1:0]        cfg_wr_data
);

  import pfba_pkg::*;

  localparam int AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int CAP = (BITMAP_WORDS < ADDRESSABLE_WORDS) ? BITMAP_WORDS : ADDRESSABLE_WORDS;
  localparam logic [CFG_W-1:0] CAP_L   = CFG_W'(CAP);
  localparam logic [16:0]      WORDS_L = 17'(BITMAP_WORDS);
  localparam logic [AW-1:0]    LAST_L  = AW'(BITMAP_WORDS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_MOD,
    ST_SCAN,
    ST_DELIVER
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [CFG_W-1:0]       words_in_use_r;
  cmd_t                   cmd_r, cmd_nxt;
  logic [PAGE_W-1:0]      page_r, page_nxt;
  logic [CFG_W-1:0]       limit_r, limit_nxt;
  logic [CFG_W-1:0]       scan_addr_r, scan_addr_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [WORD_IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  out_item_t              res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;

  logic [16:0]            in_word17;
  logic                   in_range;
  logic [16:0]            page_word17;
  logic [AW-1:0]          page_addr;
  logic [16:0]            scan_word17;
  logic [AW-1:0]          scan_addr;
  logic [WORD_BITS-1:0]   bit_mask;
  logic [WORD_BITS-1:0]   free_bits;
  logic [WORD_BITS-1:0]   low_free;
  logic [BIT_SEL_W-1:0]   low_idx;
  logic                   slot_free;
  logic                   in_xfer;
  logic                   scan_issue;

  pfba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_word17   = 17'(in_data.page_number[PAGE_W-1:BIT_SEL_W]);
  assign in_range    = (in_word17 < WORDS_L);
  assign page_word17 = 17'(page_r[PAGE_W-1:BIT_SEL_W]);
  assign page_addr   = page_word17[AW-1:0];
  assign scan_word17 = 17'(scan_addr_r);
  assign scan_addr   = scan_word17[AW-1:0];
  assign bit_mask    = WORD_BITS'(1) << page_r[BIT_SEL_W-1:0];

  // Isolate the lowest clear bit, then encode its position.
  assign free_bits = ~ram_rdata;
  assign low_free  = free_bits & (~free_bits + WORD_BITS'(1));

  always_comb begin
    low_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low_free[j]) begin
        low_idx = low_idx | BIT_SEL_W'(j);
      end
    end
  end

  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign ram_raddr  = (state_r == ST_SCAN) ? scan_addr : page_addr;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cmd_nxt       = cmd_r;
    page_nxt      = page_r;
    limit_nxt     = limit_r;
    scan_addr_nxt = scan_addr_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = page_addr;
    ram_wdata     = '0;
    scan_issue    = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_L) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt  = in_data.command;
          page_nxt = in_data.page_number;
          res_nxt  = '0;
          if (in_data.command == CMD_FIND) begin
            limit_nxt     = (words_in_use_r > CAP_L) ? CAP_L : words_in_use_r;
            scan_addr_nxt = '0;
            chk_vld_nxt   = 1'b0;
            state_nxt     = ST_SCAN;
          end else if (in_range) begin
            state_nxt = ST_RD;
          end else begin
            // A page past the store: nothing changes and test reports it as used.
            state_nxt = ST_DELIVER;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        case (cmd_r)
          CMD_MARK_USED: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | bit_mask;
          end
          CMD_MARK_FREE: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bit_mask;
          end
          CMD_TEST: begin
            res_nxt.page_free = ((ram_rdata & bit_mask) == '0);
          end
          default: begin
          end
        endcase
        state_nxt = ST_DELIVER;
      end
      ST_SCAN: begin
        // The read issued last cycle is checked while the next word is read.
        if (chk_vld_r && (ram_rdata != FULL_WORD)) begin
          res_nxt.found_page = {chk_idx_r, low_idx};
          state_nxt          = ST_DELIVER;
        end else if (scan_addr_r < limit_r) begin
          scan_issue    = 1'b1;
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = scan_addr_r[WORD_IDX_W-1:0];
          scan_addr_nxt = scan_addr_r + CFG_W'(1);
        end else begin
          res_nxt.out_of_memory = 1'b1;
          state_nxt             = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      words_in_use_r <= WORDS_IN_USE_RST;
      chk_vld_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        words_in_use_r <= cfg_wr_data;
      end
    end
    cmd_r       <= cmd_nxt;
    page_r      <= page_nxt;
    limit_r     <= limit_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("command taken during the clearing pass");

  a_ram_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_CLEAR) || (state_r == ST_MOD)))
    else $error("bitmap written outside clear or modify");

  a_scan_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    scan_issue |-> (scan_addr_r < limit_r) && (limit_r <= CAP_L))
    else $error("find read beyond the search limit");

  a_oom_zero_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_of_memory) |->
      ((out_data_r.found_page == '0) && !out_data_r.page_free))
    else $error("out-of-memory result carries a page");

endmodule

@@ sv/pfba_ram.sv @@
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
